@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the port-level checker in rtl/core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define CRBT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("crbt assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define CRBT_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("crbt assertion failed");

`endif

@@ rtl/core/crbt_pkg.sv @@
// Package: types, mode and kind codes, character constants of the tokenizer.
package crbt_pkg;

    localparam int MODE_W = 3;
    localparam int KIND_W = 3;
    localparam int CHAR_W = 8;

    // Parse modes
    localparam logic [MODE_W-1:0] MODE_SEL_SKIP  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SEL_TEXT  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_NAME_SKIP = 3'd2;
    localparam logic [MODE_W-1:0] MODE_NAME_TEXT = 3'd3;
    localparam logic [MODE_W-1:0] MODE_VAL_SKIP  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_VAL_TEXT  = 3'd5;

    // Token kinds
    localparam logic [KIND_W-1:0] KIND_SEL_CHAR    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_NAME_CHAR   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_VAL_CHAR    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_SEL_COMMIT  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_SEL_DISCARD = 3'd4;
    localparam logic [KIND_W-1:0] KIND_PAIR_COMMIT = 3'd5;
    localparam logic [KIND_W-1:0] KIND_NAME_DISC   = 3'd6;

    // Characters with a role of their own
    localparam logic [CHAR_W-1:0] CH_LBRACE = 8'h7B;
    localparam logic [CHAR_W-1:0] CH_RBRACE = 8'h7D;
    localparam logic [CHAR_W-1:0] CH_SEMI   = 8'h3B;
    localparam logic [CHAR_W-1:0] CH_COLON  = 8'h3A;
    localparam logic [CHAR_W-1:0] CH_NL     = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_AT     = 8'h40;
    localparam logic [CHAR_W-1:0] CH_HASH   = 8'h23;
    localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;

    // Token queue; depth must be a power of two
    localparam int QUEUE_DEPTH = 4;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [CHAR_W-1:0] out_char;
        logic              stream_done;
        logic              run_last;
    } token_t;

    // Decoder result for one character: up to two tokens and the new mode
    typedef struct packed {
        logic [1:0]        count;
        token_t            first;
        token_t            second;
        logic [MODE_W-1:0] mode_next;
    } dec_t;

endpackage

@@ rtl/core/crbt_if.sv @@
// Channel interfaces: character input and token output.
interface crbt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       final_char;

    modport source (output valid, output ch, output final_char, input ready);
    modport sink (input valid, input ch, input final_char, output ready);
endinterface

interface crbt_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [7:0] out_char;
    logic       stream_done;
    logic       run_last;

    modport source (output valid, output kind, output out_char, output stream_done,
                    output run_last, input ready);
    modport sink (input valid, input kind, input out_char, input stream_done,
                  input run_last, output ready);
endinterface

@@ rtl/core/crbt_decode.sv @@
// Character class decode and mode transition for one character.
module crbt_decode
(
    input  logic [7:0]         ch,
    input  logic               final_char,
    input  logic [2:0]         mode_cur,
    output crbt_pkg::dec_t     dec
);
    import crbt_pkg::*;

    localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_DOT    = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_DASH   = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_LBRACK = 8'h5B;
    localparam logic [CHAR_W-1:0] CH_RBRACK = 8'h5D;
    localparam logic [CHAR_W-1:0] CH_DQUOTE = 8'h22;
    localparam logic [CHAR_W-1:0] CH_SQUOTE = 8'h27;

    logic              is_letter;
    logic              is_digit;
    logic              sel_start;
    logic              name_char;
    logic              val_start;
    logic [MODE_W-1:0] mode;
    logic [MODE_W-1:0] mode_mid;
    logic              tok_hit;
    token_t            tok_char;
    token_t            tok_end;

    assign is_letter = (ch >= 8'h61 && ch <= 8'h7A) || (ch >= 8'h41 && ch <= 8'h5A);
    assign is_digit  = (ch >= 8'h30 && ch <= 8'h39);
    assign sel_start = is_letter || is_digit || ch == CH_AT || ch == CH_STAR ||
                       ch == CH_DOT || ch == CH_COLON || ch == CH_DASH ||
                       ch == CH_HASH || ch == CH_LBRACK || ch == CH_RBRACK;
    assign name_char = is_letter || is_digit || ch == CH_DASH;
    assign val_start = is_letter || is_digit || ch == CH_DASH || ch == CH_DOT ||
                       ch == CH_HASH || ch == CH_DQUOTE || ch == CH_SQUOTE;

    // unreachable codes behave as selector skip
    assign mode = (mode_cur > MODE_VAL_TEXT) ? MODE_SEL_SKIP : mode_cur;

    always_comb
    begin
        mode_mid = mode;
        tok_hit  = 1'b0;
        tok_char = '0;
        unique case (mode)
            MODE_SEL_TEXT:
            begin
                tok_hit = 1'b1;
                if (ch == CH_LBRACE)
                begin
                    tok_char.kind = KIND_SEL_COMMIT;
                    mode_mid      = MODE_NAME_SKIP;
                end
                else
                begin
                    tok_char.kind     = KIND_SEL_CHAR;
                    tok_char.out_char = ch;
                end
            end
            MODE_NAME_SKIP:
            begin
                if (ch == CH_RBRACE)
                begin
                    mode_mid = MODE_SEL_SKIP;
                end
                else if (name_char)
                begin
                    tok_hit           = 1'b1;
                    tok_char.kind     = KIND_NAME_CHAR;
                    tok_char.out_char = ch;
                    mode_mid          = MODE_NAME_TEXT;
                end
            end
            MODE_NAME_TEXT:
            begin
                if (ch == CH_COLON)
                begin
                    mode_mid = MODE_VAL_SKIP;
                end
                else if (ch == CH_SEMI)
                begin
                    tok_hit       = 1'b1;
                    tok_char.kind = KIND_NAME_DISC;
                    mode_mid      = MODE_NAME_SKIP;
                end
                else if (ch != CH_NL)
                begin
                    tok_hit           = 1'b1;
                    tok_char.kind     = KIND_NAME_CHAR;
                    tok_char.out_char = ch;
                end
            end
            MODE_VAL_SKIP:
            begin
                if (val_start)
                begin
                    tok_hit           = 1'b1;
                    tok_char.kind     = KIND_VAL_CHAR;
                    tok_char.out_char = ch;
                    mode_mid          = MODE_VAL_TEXT;
                end
            end
            MODE_VAL_TEXT:
            begin
                tok_hit = 1'b1;
                if (ch == CH_SEMI)
                begin
                    tok_char.kind = KIND_PAIR_COMMIT;
                    mode_mid      = MODE_NAME_SKIP;
                end
                else if (ch == CH_RBRACE)
                begin
                    tok_char.kind = KIND_PAIR_COMMIT;
                    mode_mid      = MODE_SEL_SKIP;
                end
                else
                begin
                    tok_char.kind     = KIND_VAL_CHAR;
                    tok_char.out_char = (ch == CH_NL) ? CH_SPACE : ch;
                end
            end
            default: // selector skip
            begin
                if (ch == CH_LBRACE)
                begin
                    tok_hit       = 1'b1;
                    tok_char.kind = KIND_SEL_COMMIT;
                    mode_mid      = MODE_NAME_SKIP;
                end
                else if (sel_start)
                begin
                    tok_hit           = 1'b1;
                    tok_char.kind     = KIND_SEL_CHAR;
                    tok_char.out_char = ch;
                    mode_mid          = MODE_SEL_TEXT;
                end
            end
        endcase
    end

    // end-of-stylesheet event, seen against the mode after this character
    always_comb
    begin
        tok_end             = '0;
        tok_end.stream_done = 1'b1;
        tok_end.run_last    = 1'b1;
        if (mode_mid == MODE_SEL_SKIP || mode_mid == MODE_SEL_TEXT)
        begin
            tok_end.kind = KIND_SEL_DISCARD;
        end
        else
        begin
            tok_end.kind = KIND_PAIR_COMMIT;
        end
    end

    always_comb
    begin
        dec           = '0;
        dec.mode_next = final_char ? MODE_SEL_SKIP : mode_mid;
        if (tok_hit)
        begin
            dec.first          = tok_char;
            dec.first.run_last = !final_char;
            dec.second         = tok_end;
            dec.count          = final_char ? 2'd2 : 2'd1;
        end
        else
        begin
            dec.first = tok_end;
            dec.count = final_char ? 2'd1 : 2'd0;
        end
    end

endmodule

@@ rtl/core/crbt_queue.sv @@
// Token queue: takes up to two tokens per cycle, hands out one per cycle while the sink is ready.
module crbt_queue
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  crbt_pkg::dec_t   dec,
    output logic             space,
    crbt_out_if.source       token
);
    import crbt_pkg::*;

    token_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   wr_ptr_inc;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [1:0]         n_push;
    logic               pop;
    token_t             head;

    assign n_push      = push ? dec.count : 2'd0;
    assign pop         = token.valid && token.ready;
    assign wr_ptr_inc  = wr_ptr_reg + PTR_W'(1);
    assign wr_ptr_next = wr_ptr_reg + PTR_W'(n_push);
    assign rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
    assign count_next  = count_reg + CNT_W'(n_push) - CNT_W'(pop);

    // room for a worst-case character regardless of the output side
    assign space = (count_reg <= CNT_W'(QUEUE_DEPTH - 2));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (n_push != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= dec.first;
        end
        if (n_push == 2'd2)
        begin
            entry_reg[wr_ptr_inc] <= dec.second;
        end
    end

    assign head              = entry_reg[rd_ptr_reg];
    assign token.valid       = (count_reg != '0);
    assign token.kind        = head.kind;
    assign token.out_char    = head.out_char;
    assign token.stream_done = head.stream_done;
    assign token.run_last    = head.run_last;

endmodule

@@ rtl/core/css_rule_block_tokenizer.sv @@
// Top level of the CSS rule-block tokenizer.
// The block reads a stylesheet one character per transfer on the text channel
// and tags each useful character as selector, property name or property value,
// plus commit and discard events, on the token channel. One character is taken
// every cycle while the four-entry token queue has room for two tokens; a
// character gives zero, one or two tokens, registered in the queue before they
// show on the token channel. The token side hands out one token per cycle
// while token.ready is high, so one character per cycle holds as long as,
// on average, no more than one token comes per character; the queue occupancy
// alone sets text.ready, with no path from token.ready to text.ready.
// After the character flagged final_char, an end event (stream_done set) is
// given and the mode returns to selector skip, so a new stylesheet may follow
// at once. There are no configuration registers.
module css_rule_block_tokenizer
(
    input  logic        clk,
    input  logic        rst_n,
    crbt_in_if.sink     text,
    crbt_out_if.source  token
);
    import crbt_pkg::*;

    logic [MODE_W-1:0] mode_reg;
    logic [MODE_W-1:0] mode_next;
    logic              accept;
    logic              space;
    dec_t              dec;

    assign text.ready = space;
    assign accept     = text.valid && text.ready;

    // class decode and next mode, straight from the incoming character
    crbt_decode u_decode
    (
        .ch         (text.ch),
        .final_char (text.final_char),
        .mode_cur   (mode_reg),
        .dec        (dec)
    );

    assign mode_next = accept ? dec.mode_next : mode_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_SEL_SKIP;
        end
        else
        begin
            mode_reg <= mode_next;
        end
    end

    // result registers: tokens wait here until the sink takes them
    crbt_queue u_queue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (accept),
        .dec   (dec),
        .space (space),
        .token (token)
    );

endmodule

@@ rtl/core/crbt_checker.sv @@
// Port-level checker for the tokenizer, bound to the top level.
`include "assert_macros.svh"

module crbt_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       tok_valid,
    input logic       tok_ready,
    input logic [2:0] tok_kind,
    input logic [7:0] tok_char,
    input logic       tok_done,
    input logic       tok_last
);
    import crbt_pkg::*;

    // end event always closes its character's tokens
    `CRBT_ASSERT_IMP(a_done_is_last, tok_valid && tok_done, tok_last)

    // end event is a selector discard or a pair commit
    `CRBT_ASSERT_IMP(a_done_kind, tok_valid && tok_done,
        tok_kind == KIND_SEL_DISCARD || tok_kind == KIND_PAIR_COMMIT)

    // events carry no character
    `CRBT_ASSERT_IMP(a_event_no_char,
        tok_valid && tok_kind != KIND_SEL_CHAR && tok_kind != KIND_NAME_CHAR &&
        tok_kind != KIND_VAL_CHAR, tok_char == '0)

    // newlines inside values come out as spaces
    `CRBT_ASSERT_IMP(a_val_no_newline, tok_valid && tok_kind == KIND_VAL_CHAR,
        tok_char != CH_NL)

    // a token offered and not taken stays offered
    `CRBT_ASSERT_NXT(a_tok_hold, tok_valid && !tok_ready, tok_valid)

endmodule

bind css_rule_block_tokenizer crbt_checker u_crbt_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .tok_valid (token.valid),
    .tok_ready (token.ready),
    .tok_kind  (token.kind),
    .tok_char  (token.out_char),
    .tok_done  (token.stream_done),
    .tok_last  (token.run_last)
);

@@ dv/crbt_checker.sv @@
`timescale 1ns / 100ps
// Token checker: predicts tokens from accepted characters and compares them in order.
module crbt_scoreboard
(
    input  logic clk,
    input  logic rst_n,
    crbt_in_if   text,
    crbt_out_if  token,
    output int   fail_count,
    output int   pending_count,
    output int   char_count,
    output int   token_count,
    output int   sheet_count
);
    import crbt_pkg::*;

    token_t            expected_tokens[$];
    logic [MODE_W-1:0] mode_q = MODE_SEL_SKIP;
    int                fails = 0;
    int                chars = 0;
    int                tokens = 0;
    int                sheets = 0;

    function automatic bit is_letter(input logic [CHAR_W-1:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit is_digit(input logic [CHAR_W-1:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic token_t make_token(input logic [KIND_W-1:0] k,
                                          input logic [CHAR_W-1:0] c,
                                          input logic              done);
        token_t t;
        t.kind        = k;
        t.out_char    = c;
        t.stream_done = done;
        t.run_last    = 1'b0;
        return t;
    endfunction

    // Next-token prediction for one accepted character; updates the parse mode.
    function automatic void tokenize_char(input logic [CHAR_W-1:0] c, input logic fin);
        logic [MODE_W-1:0] m;
        token_t            run[$];
        bit                alnum;
        m     = (mode_q > MODE_VAL_TEXT) ? MODE_SEL_SKIP : mode_q;
        alnum = is_letter(c) || is_digit(c);
        case (m)
            MODE_SEL_SKIP:
            begin
                if (c == CH_LBRACE)
                begin
                    run = {run, make_token(KIND_SEL_COMMIT, '0, 1'b0)};
                    m = MODE_NAME_SKIP;
                end
                else if (alnum || c == CH_AT || c == "*" || c == "." || c == CH_COLON ||
                         c == "-" || c == CH_HASH || c == "[" || c == "]")
                begin
                    run = {run, make_token(KIND_SEL_CHAR, c, 1'b0)};
                    m = MODE_SEL_TEXT;
                end
            end
            MODE_SEL_TEXT:
            begin
                if (c == CH_LBRACE)
                begin
                    run = {run, make_token(KIND_SEL_COMMIT, '0, 1'b0)};
                    m = MODE_NAME_SKIP;
                end
                else
                    run = {run, make_token(KIND_SEL_CHAR, c, 1'b0)};
            end
            MODE_NAME_SKIP:
            begin
                if (c == CH_RBRACE)
                    m = MODE_SEL_SKIP;
                else if (alnum || c == "-")
                begin
                    run = {run, make_token(KIND_NAME_CHAR, c, 1'b0)};
                    m = MODE_NAME_TEXT;
                end
            end
            MODE_NAME_TEXT:
            begin
                if (c == CH_COLON)
                    m = MODE_VAL_SKIP;
                else if (c == CH_SEMI)
                begin
                    run = {run, make_token(KIND_NAME_DISC, '0, 1'b0)};
                    m = MODE_NAME_SKIP;
                end
                else if (c != CH_NL)
                    run = {run, make_token(KIND_NAME_CHAR, c, 1'b0)};
            end
            MODE_VAL_SKIP:
            begin
                if (alnum || c == "-" || c == "." || c == CH_HASH || c == 8'h22 || c == 8'h27)
                begin
                    run = {run, make_token(KIND_VAL_CHAR, c, 1'b0)};
                    m = MODE_VAL_TEXT;
                end
            end
            default:
            begin
                if (c == CH_SEMI)
                begin
                    run = {run, make_token(KIND_PAIR_COMMIT, '0, 1'b0)};
                    m = MODE_NAME_SKIP;
                end
                else if (c == CH_RBRACE)
                begin
                    run = {run, make_token(KIND_PAIR_COMMIT, '0, 1'b0)};
                    m = MODE_SEL_SKIP;
                end
                else
                    run = {run, make_token(KIND_VAL_CHAR, (c == CH_NL) ? CH_SPACE : c, 1'b0)};
            end
        endcase

        // end of stylesheet: selector modes discard, all others commit a pair
        if (fin)
        begin
            if (m == MODE_SEL_SKIP || m == MODE_SEL_TEXT)
                run = {run, make_token(KIND_SEL_DISCARD, '0, 1'b1)};
            else
                run = {run, make_token(KIND_PAIR_COMMIT, '0, 1'b1)};
            m = MODE_SEL_SKIP;
        end

        if (run.size() > 0)
            run[run.size()-1].run_last = 1'b1;
        expected_tokens = {expected_tokens, run};
        mode_q = m;
    endfunction

    function automatic void check_field(input string name, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want)
        begin
            fails++;
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        token_t want;
        if (!rst_n)
        begin
            mode_q = MODE_SEL_SKIP;
            expected_tokens.delete();
        end
        else
        begin
            // tokens come out of the queue registers after their character is taken, so compare first
            if (token.valid && token.ready)
            begin
                tokens++;
                if (token.stream_done === 1'b1)
                    sheets++;
                if (expected_tokens.size() == 0)
                begin
                    fails++;
                    $error("token with nothing expected: kind %0d char %0h",
                           token.kind, token.out_char);
                end
                else
                begin
                    want = expected_tokens.pop_front();
                    check_field("kind", 8'(want.kind), 8'(token.kind));
                    check_field("out_char", want.out_char, token.out_char);
                    check_field("stream_done", 8'(want.stream_done), 8'(token.stream_done));
                    check_field("run_last", 8'(want.run_last), 8'(token.run_last));
                end
            end
            if (text.valid && text.ready)
            begin
                chars++;
                tokenize_char(text.ch, text.final_char);
            end
        end
        fail_count    <= fails;
        pending_count <= expected_tokens.size();
        char_count    <= chars;
        token_count   <= tokens;
        sheet_count   <= sheets;
    end

endmodule

@@ dv/tb_css_rule_block_tokenizer.sv @@
`timescale 1ns / 100ps
// Testbench top: clock, reset, character and token stimulus, and the final verdict.
module tb_css_rule_block_tokenizer;
    import crbt_pkg::*;

    localparam int RANDOM_CHARS = 1800;
    localparam int DRAIN_CYCLES = 20;

    // Directed opening: {final_char, ch}. Walks every mode, both kinds of
    // end event, NUL and high bytes, newline in each text mode.
    localparam logic [8:0] DIRECTED_TEXT [28] = '{
        {1'b0, 8'h00},      // NUL dropped in selector skip
        {1'b0, 8'hFF},      // high byte dropped in selector skip
        {1'b0, 8'h61},      // 'a' opens selector text
        {1'b0, 8'hFF},      // high byte kept inside selector
        {1'b0, CH_NL},      // newline kept inside selector
        {1'b0, CH_LBRACE},  // selector commit
        {1'b0, CH_RBRACE},  // empty block, back to selector skip
        {1'b0, CH_AT},
        {1'b0, CH_LBRACE},
        {1'b0, 8'h6E},      // 'n' name char
        {1'b0, CH_NL},      // dropped in name text
        {1'b0, CH_SEMI},    // name discard
        {1'b0, 8'h6D},      // 'm'
        {1'b0, CH_COLON},   // into value skip
        {1'b0, CH_SEMI},    // ignored in value skip
        {1'b0, 8'h22},      // double quote opens value
        {1'b0, CH_NL},      // becomes a space
        {1'b0, 8'h00},      // NUL kept in value text
        {1'b0, CH_SEMI},    // pair commit, name skip
        {1'b0, 8'h6B},      // 'k'
        {1'b0, CH_COLON},
        {1'b0, 8'h37},      // '7'
        {1'b0, CH_RBRACE},  // pair commit, selector skip
        {1'b0, CH_HASH},
        {1'b1, 8'h7A},      // 'z' then selector discard at end
        {1'b0, CH_LBRACE},
        {1'b0, 8'h70},      // 'p'
        {1'b1, CH_COLON}    // ends in value skip: empty pair commit
    };

    localparam string SEL_POOL  = "abcdefghijklmnopqrstuvwxyzABXYZ0123456789.#:-*[]@ >,=\n";
    localparam string NAME_POOL = "abcdefghijklmnopqrstuvwxyz-0123456789ABZ";
    localparam string VAL_POOL  = "abcdefghijklmnopqrstuvwxyz0123456789 #.-\"'%(),!\n";
    localparam string WS_POOL   = " \n\t";
    localparam string MARK_POOL = "{};:\n a-";

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    int fail_count;
    int pending_count;
    int char_count;
    int token_count;
    int sheet_count;

    // idle-free stretches on each side
    bit text_burst  = 1'b0;
    bit token_burst = 1'b0;

    logic [7:0] sheet_bytes[$];

    crbt_in_if  text_if ();
    crbt_out_if token_if ();

    css_rule_block_tokenizer i_dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .text  (text_if),
        .token (token_if)
    );

    crbt_scoreboard i_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .text          (text_if),
        .token         (token_if),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .char_count    (char_count),
        .token_count   (token_count),
        .sheet_count   (sheet_count)
    );

    always #2 clk = ~clk;

    // Hard stop well beyond the slowest legal run.
    initial
    begin
        #2000000;
        $display("tb_css_rule_block_tokenizer NOT OK");
        $finish;
    end

    // One character transfer: optional idle gap, then hold valid until ready.
    task automatic send_char(input logic [7:0] c, input logic fin);
        int gap;
        gap = text_burst ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            text_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        text_if.valid      <= 1'b1;
        text_if.ch         <= c;
        text_if.final_char <= fin;
        @(posedge clk);
        while (!text_if.ready)
            @(posedge clk);
    endtask

    // Append one byte to the stylesheet under construction.
    task automatic append_byte(input logic [7:0] b);
        sheet_bytes = {sheet_bytes, b};
    endtask

    // Append a run of pool characters; now and then a raw byte slips in.
    task automatic add_run(input string pool, input int lo, input int hi);
        int n;
        n = $urandom_range(lo, hi);
        repeat (n)
        begin
            if ($urandom_range(0, 24) == 0)
                append_byte(8'($urandom_range(0, 255)));
            else
                append_byte(pool[$urandom_range(0, pool.len() - 1)]);
        end
    endtask

    // Mostly well-formed rule blocks with random content; some are cut short,
    // some are pure noise biased toward the delimiters.
    task automatic build_sheet();
        int n_rules;
        int n_decls;
        int cut;
        sheet_bytes.delete();
        if ($urandom_range(0, 4) == 0)
        begin
            repeat ($urandom_range(1, 16))
            begin
                if ($urandom_range(0, 1) == 0)
                    append_byte(8'($urandom_range(0, 255)));
                else
                    append_byte(MARK_POOL[$urandom_range(0, MARK_POOL.len() - 1)]);
            end
            return;
        end
        n_rules = $urandom_range(1, 3);
        repeat (n_rules)
        begin
            add_run(WS_POOL, 0, 2);
            add_run(SEL_POOL, 1, 6);
            append_byte(CH_LBRACE);
            n_decls = $urandom_range(0, 3);
            for (int d = 0; d < n_decls; d++)
            begin
                add_run(WS_POOL, 0, 2);
                add_run(NAME_POOL, 1, 5);
                if ($urandom_range(0, 5) == 0)
                begin
                    // name with no value
                    append_byte(CH_SEMI);
                    continue;
                end
                if ($urandom_range(0, 4) == 0)
                    append_byte(CH_NL);
                append_byte(CH_COLON);
                add_run(" ", 0, 1);
                add_run(VAL_POOL, 1, 6);
                if (d != n_decls - 1 || $urandom_range(0, 2) != 0)
                    append_byte(CH_SEMI);
            end
            add_run(WS_POOL, 0, 1);
            append_byte(CH_RBRACE);
        end
        // truncated stylesheet: end lands in whatever mode it reached
        if ($urandom_range(0, 5) == 0)
        begin
            cut = $urandom_range(1, sheet_bytes.size());
            while (sheet_bytes.size() > cut)
                void'(sheet_bytes.pop_back());
        end
    endtask

    // Token side: random stall before each transfer, with idle-free stretches.
    initial
    begin
        int gap;
        token_if.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                token_burst = !token_burst;
            gap = token_burst ? 0 : $urandom_range(0, 11);
            if (gap > 0)
            begin
                token_if.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            token_if.ready <= 1'b1;
            @(posedge clk);
            while (!token_if.valid)
                @(posedge clk);
        end
    end

    // Character side and verdict.
    initial
    begin
        int sent;
        sent = 0;
        text_if.valid      <= 1'b0;
        text_if.ch         <= '0;
        text_if.final_char <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        foreach (DIRECTED_TEXT[i])
            send_char(DIRECTED_TEXT[i][7:0], DIRECTED_TEXT[i][8]);

        while (sent < RANDOM_CHARS)
        begin
            if ($urandom_range(0, 3) == 0)
                text_burst = !text_burst;
            build_sheet();
            foreach (sheet_bytes[i])
                send_char(sheet_bytes[i], i == sheet_bytes.size() - 1);
            sent += sheet_bytes.size();
        end
        text_if.valid <= 1'b0;

        // let the last character reach the checker, drain, then leave room
        // for any stray token
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d characters over %0d stylesheets; %0d tokens compared.",
                 char_count, sheet_count, token_count);
        if (fail_count == 0 && pending_count == 0)
            $display("tb_css_rule_block_tokenizer OK");
        else
            $display("tb_css_rule_block_tokenizer NOT OK");
        $finish;
    end

endmodule

@@ css_rule_block_tokenizer.f @@
+incdir+rtl/core
rtl/core/crbt_pkg.sv
rtl/core/crbt_if.sv
rtl/core/crbt_decode.sv
rtl/core/crbt_queue.sv
rtl/core/css_rule_block_tokenizer.sv
rtl/core/crbt_checker.sv
dv/crbt_checker.sv
dv/tb_css_rule_block_tokenizer.sv
